@@ sv/qca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qca_pkg
// Shared types, constants and helpers for the quadrature capture averager.
// ----------------------------------------------------------------------------
package qca_pkg;

    localparam int MAX_SAMPLES = 2048;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int TICK_W      = 11;
    localparam int LEN_W       = 12;
    localparam int RUNS_W      = 8;
    localparam int POS_W       = 24;
    localparam int MEAN_W      = 32;
    localparam int ACC_W       = MEAN_W + RUNS_W + 1;
    localparam int DIVR_W      = RUNS_W + 1;
    localparam int STEP_W      = $clog2(ACC_W + 1);

    localparam logic [LEN_W-1:0]  RST_CAPTURE_LENGTH = 12'd1200;
    localparam logic [LEN_W-1:0]  RST_DRIVE_LENGTH   = 12'd600;
    localparam logic [RUNS_W-1:0] RST_RUN_COUNT      = 8'd10;
    localparam logic [RUNS_W-1:0] RUNS_TOP           = 8'd255;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPTURE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_DRIVE_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_RUN_COUNT      = 2'd2;

    typedef enum logic [1:0] {
        ACT_ENC   = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_START = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_RDOUT,
        M_MUL,
        M_DIV,
        M_WRITE
    } t_mstate;

    typedef struct packed {
        t_action           action;
        logic              enc_a;
        logic              enc_b;
        logic [TICK_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic                     motor_on;
        logic                     capturing;
        logic [RUNS_W-1:0]        runs_finished;
        logic                     series_done;
        logic signed [MEAN_W-1:0] mean_value;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] count;
        logic [TICK_W-1:0]       tick_index;
        logic                    run_active;
        logic                    drive_active;
        logic [RUNS_W-1:0]       runs_done;
        logic                    series_done;
    } t_run_stat;

    typedef struct packed {
        logic                    fold;
        logic                    read;
        logic [TICK_W-1:0]       idx;
        logic signed [POS_W-1:0] count;
        logic [RUNS_W-1:0]       k;
    } t_mean_req;

    typedef struct packed {
        logic                     done;
        logic signed [MEAN_W-1:0] mean;
    } t_mean_rsp;

    // next phase in forward order 00 -> 01 -> 11 -> 10 -> 00
    function automatic logic [1:0] fwd_next(input logic [1:0] phase);
        logic [1:0] r;
        case (phase)
            2'b00:   r = 2'b01;
            2'b01:   r = 2'b11;
            2'b11:   r = 2'b10;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

endpackage

@@ sv/quadrature_capture_averager_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_capture_averager_top
// Quadrature decoder with per-tick ensemble averaging of captured position.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------
//  input    | in        | i_in_valid / o_in_stall      | i_in_item (t_in_item)
//  output   | out       | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//  config   | in        | i_cfg_we                     | i_cfg_index, i_cfg_data
//
//  Encoder, start and idle-tick items go straight to hand-off; a read also
//  waits on the synchronous mean store read. A tick inside a run goes through
//  store read, one multiply, 41 bit-serial restoring-divide steps, write-back
//  and result hand-off.
//  Reset clears control state only; the mean store is not cleared and an
//  entry reads as valid once it has been folded into.
//  A result waits in the output register while the next item is accepted;
//  a held output stalls the finishing item in its last cycle.
// ----------------------------------------------------------------------------
module quadrature_capture_averager_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  qca_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output qca_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [qca_pkg::LEN_W-1:0] i_cfg_data
);

    qca_pkg::t_state                   r_state, n_state;
    logic signed [qca_pkg::MEAN_W-1:0] r_mean, n_mean;
    qca_pkg::t_out_item                r_out;
    logic                              r_out_valid;

    logic                              accept;
    logic                              load_out;
    qca_pkg::t_run_stat                stat;
    qca_pkg::t_mean_req                mreq;
    qca_pkg::t_mean_rsp                mrsp;

    // accept only while idle; the item's control update happens at accept
    assign o_in_stall = (r_state != qca_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    qca_run_ctrl u_run_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat)
    );

    qca_mean_unit u_mean_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    // fold request carries the pre-update count, index and run number
    always_comb begin
        mreq.fold  = accept && (i_in_item.action == qca_pkg::ACT_TICK) && stat.run_active;
        mreq.read  = accept && (i_in_item.action == qca_pkg::ACT_READ);
        mreq.idx   = (i_in_item.action == qca_pkg::ACT_READ) ? i_in_item.read_index
                                                             : stat.tick_index;
        mreq.count = stat.count;
        mreq.k     = stat.runs_done;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qca_pkg::ST_IDLE: begin
                if (mreq.fold || mreq.read) begin
                    n_state = qca_pkg::ST_BUSY;
                end else if (accept) begin
                    n_state = qca_pkg::ST_DONE;
                end
            end
            qca_pkg::ST_BUSY: begin
                if (mrsp.done) begin
                    n_state = qca_pkg::ST_DONE;
                end
            end
            qca_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = qca_pkg::ST_IDLE;
                end
            end
            default: n_state = qca_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        n_mean   = r_mean;
        load_out = 1'b0;
        case (r_state)
            qca_pkg::ST_IDLE: begin
                if (accept) begin
                    n_mean = '0;
                end
            end
            qca_pkg::ST_BUSY: begin
                if (mrsp.done) begin
                    n_mean = mrsp.mean;
                end
            end
            qca_pkg::ST_DONE: begin
                load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qca_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // no other item runs between accept and hand-off, so live status is this item's
    always_ff @(posedge i_clk) begin
        r_mean <= n_mean;
        if (load_out) begin
            r_out.position      <= stat.count;
            r_out.motor_on      <= stat.drive_active;
            r_out.capturing     <= stat.run_active;
            r_out.runs_finished <= stat.runs_done;
            r_out.series_done   <= stat.series_done;
            r_out.mean_value    <= r_mean;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ sv/qca_run_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qca_run_ctrl
// Encoder decode, run and drive sequencing, run counting and config registers.
// ----------------------------------------------------------------------------
module qca_run_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  qca_pkg::t_in_item          i_item,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [qca_pkg::LEN_W-1:0]  i_cfg_data,
    output qca_pkg::t_run_stat         o_stat
);

    logic [qca_pkg::LEN_W-1:0]         r_capture_length;
    logic [qca_pkg::LEN_W-1:0]         r_drive_length;
    logic [qca_pkg::RUNS_W-1:0]        r_run_count;

    logic [1:0]                        r_prev_phase, n_prev_phase;
    logic signed [qca_pkg::POS_W-1:0]  r_count, n_count;
    logic [qca_pkg::TICK_W-1:0]        r_tick, n_tick;
    logic                              r_run, n_run;
    logic                              r_drive, n_drive;
    logic [qca_pkg::RUNS_W-1:0]        r_runs, n_runs;

    logic [1:0]                        phase;
    logic [qca_pkg::LEN_W-1:0]         len;
    logic [qca_pkg::LEN_W-1:0]         next_tick;

    always_comb begin
        phase = {i_item.enc_a, i_item.enc_b};
        len = r_capture_length;
        if (len == '0) begin
            len = qca_pkg::LEN_W'(1);
        end
        if (32'(len) > qca_pkg::MAX_SAMPLES) begin
            len = qca_pkg::LEN_W'(qca_pkg::MAX_SAMPLES);
        end
        next_tick = qca_pkg::LEN_W'(r_tick) + qca_pkg::LEN_W'(1);

        n_prev_phase = r_prev_phase;
        n_count      = r_count;
        n_tick       = r_tick;
        n_run        = r_run;
        n_drive      = r_drive;
        n_runs       = r_runs;

        if (i_accept) begin
            case (i_item.action)
                qca_pkg::ACT_ENC: begin
                    // a two-bit jump or an unchanged phase leaves the count
                    if (qca_pkg::fwd_next(r_prev_phase) == phase) begin
                        if (r_count != qca_pkg::POS_MAX) begin
                            n_count = r_count + 24'sd1;
                        end
                    end else if (qca_pkg::fwd_next(phase) == r_prev_phase) begin
                        if (r_count != qca_pkg::POS_MIN) begin
                            n_count = r_count - 24'sd1;
                        end
                    end
                    n_prev_phase = phase;
                end
                qca_pkg::ACT_TICK: begin
                    if (r_run) begin
                        if (next_tick >= r_drive_length) begin
                            n_drive = 1'b0;
                        end
                        if (next_tick >= len) begin
                            n_count = '0;
                            n_tick  = '0;
                            n_run   = 1'b0;
                            n_drive = 1'b0;
                            if (r_runs != qca_pkg::RUNS_TOP) begin
                                n_runs = r_runs + 8'd1;
                            end
                        end else begin
                            n_tick = next_tick[qca_pkg::TICK_W-1:0];
                        end
                    end
                end
                qca_pkg::ACT_START: begin
                    if (!r_run) begin
                        // restart the series once it is complete
                        if (r_runs >= r_run_count) begin
                            n_runs = '0;
                        end
                        n_run   = 1'b1;
                        n_tick  = '0;
                        n_drive = (r_drive_length != '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_length <= qca_pkg::RST_CAPTURE_LENGTH;
            r_drive_length   <= qca_pkg::RST_DRIVE_LENGTH;
            r_run_count      <= qca_pkg::RST_RUN_COUNT;
            r_prev_phase     <= '0;
            r_count          <= '0;
            r_tick           <= '0;
            r_run            <= 1'b0;
            r_drive          <= 1'b0;
            r_runs           <= '0;
        end else begin
            r_prev_phase <= n_prev_phase;
            r_count      <= n_count;
            r_tick       <= n_tick;
            r_run        <= n_run;
            r_drive      <= n_drive;
            r_runs       <= n_runs;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    qca_pkg::CFG_CAPTURE_LENGTH: r_capture_length <= i_cfg_data;
                    qca_pkg::CFG_DRIVE_LENGTH:   r_drive_length   <= i_cfg_data;
                    qca_pkg::CFG_RUN_COUNT:      r_run_count      <= i_cfg_data[qca_pkg::RUNS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stat.count        = r_count;
    assign o_stat.tick_index   = r_tick;
    assign o_stat.run_active   = r_run;
    assign o_stat.drive_active = r_drive;
    assign o_stat.runs_done    = r_runs;
    assign o_stat.series_done  = (r_runs == r_run_count);

endmodule

@@ sv/qca_mean_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qca_mean_unit
// Mean store with read-modify-write fold: multiply, restoring divide, write.
// ----------------------------------------------------------------------------
module qca_mean_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qca_pkg::t_mean_req i_req,
    output qca_pkg::t_mean_rsp o_rsp
);

    logic signed [qca_pkg::MEAN_W-1:0] mem [qca_pkg::MAX_SAMPLES];

    qca_pkg::t_mstate                  r_state, n_state;
    logic [qca_pkg::ADDR_W-1:0]        r_idx;
    logic signed [qca_pkg::POS_W-1:0]  r_count;
    logic [qca_pkg::RUNS_W-1:0]        r_k;
    logic                              r_oor;
    logic signed [qca_pkg::MEAN_W-1:0] r_rdata;
    logic                              r_neg;
    logic [qca_pkg::ACC_W-1:0]         r_mag;
    logic [qca_pkg::DIVR_W-1:0]        r_rem;
    logic [qca_pkg::DIVR_W-1:0]        r_divisor;
    logic [qca_pkg::STEP_W-1:0]        r_steps;

    logic                              rd_en;
    logic [qca_pkg::ADDR_W-1:0]        rd_addr;
    logic                              wr_en;
    logic signed [qca_pkg::MEAN_W-1:0] wr_data;
    logic signed [qca_pkg::MEAN_W-1:0] old;
    logic signed [qca_pkg::ACC_W-1:0]  acc;
    logic [qca_pkg::DIVR_W:0]          rem_sh;
    logic                              q_bit;
    logic [qca_pkg::ACC_W-1:0]         quot;
    logic                              req_oor;

    assign req_oor = (32'(i_req.idx) >= qca_pkg::MAX_SAMPLES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qca_pkg::M_IDLE: begin
                if (i_req.fold) begin
                    n_state = qca_pkg::M_MUL;
                end else if (i_req.read) begin
                    n_state = qca_pkg::M_RDOUT;
                end
            end
            qca_pkg::M_RDOUT: n_state = qca_pkg::M_IDLE;
            qca_pkg::M_MUL:   n_state = qca_pkg::M_DIV;
            qca_pkg::M_DIV: begin
                if (r_steps == qca_pkg::STEP_W'(1)) begin
                    n_state = qca_pkg::M_WRITE;
                end
            end
            qca_pkg::M_WRITE: n_state = qca_pkg::M_IDLE;
            default:          n_state = qca_pkg::M_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        rd_en   = (r_state == qca_pkg::M_IDLE) && (i_req.fold || i_req.read);
        rd_addr = i_req.idx[qca_pkg::ADDR_W-1:0];

        // an entry folded with no prior runs does not contribute
        old = (r_k == '0) ? '0 : r_rdata;
        acc = {{(qca_pkg::ACC_W-qca_pkg::MEAN_W){old[qca_pkg::MEAN_W-1]}}, old}
              * $signed({{(qca_pkg::ACC_W-qca_pkg::RUNS_W){1'b0}}, r_k})
              + $signed({{(qca_pkg::ACC_W-qca_pkg::POS_W-8){r_count[qca_pkg::POS_W-1]}},
                         r_count, 8'h00});

        rem_sh = {r_rem, r_mag[qca_pkg::ACC_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_divisor});

        quot    = r_neg ? (~r_mag + qca_pkg::ACC_W'(1)) : r_mag;
        wr_data = quot[qca_pkg::MEAN_W-1:0];
        wr_en   = (r_state == qca_pkg::M_WRITE);

        o_rsp.done = (r_state == qca_pkg::M_RDOUT) || (r_state == qca_pkg::M_WRITE);
        o_rsp.mean = (r_state == qca_pkg::M_RDOUT && !r_oor) ? r_rdata : '0;
    end

    // items are taken one at a time, so a write always lands before the next read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qca_pkg::M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            qca_pkg::M_IDLE: begin
                r_idx   <= i_req.idx[qca_pkg::ADDR_W-1:0];
                r_count <= i_req.count;
                r_k     <= i_req.k;
                r_oor   <= req_oor;
            end
            qca_pkg::M_MUL: begin
                r_neg     <= acc[qca_pkg::ACC_W-1];
                r_mag     <= acc[qca_pkg::ACC_W-1] ? (~acc + qca_pkg::ACC_W'(1)) : acc;
                r_rem     <= '0;
                r_divisor <= {1'b0, r_k} + qca_pkg::DIVR_W'(1);
                r_steps   <= qca_pkg::STEP_W'(qca_pkg::ACC_W);
            end
            qca_pkg::M_DIV: begin
                // shift one dividend bit into the remainder, quotient bit into r_mag
                r_rem   <= q_bit ? qca_pkg::DIVR_W'(rem_sh - {1'b0, r_divisor})
                                 : rem_sh[qca_pkg::DIVR_W-1:0];
                r_mag   <= {r_mag[qca_pkg::ACC_W-2:0], q_bit};
                r_steps <= r_steps - qca_pkg::STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

@@ dv/qca_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qca_checker
// Watches the item and result channels of the capture averager, keeps its own
// copy of the decoder, run and mean state, and compares every result transfer
// field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
module qca_checker
    import qca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_item               i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_item              i_out_item,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [LEN_W-1:0]       i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending
);

    logic [LEN_W-1:0]         cap_len;
    logic [LEN_W-1:0]         drv_len;
    logic [RUNS_W-1:0]        run_cnt;
    logic [1:0]               last_phase;
    logic signed [POS_W-1:0]  count;
    int                       tick_idx;
    bit                       run_on;
    bit                       drive_on;
    logic [RUNS_W-1:0]        runs_done;
    logic signed [MEAN_W-1:0] mean_mem [MAX_SAMPLES];
    t_out_item                pending_status [$];
    int                       errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t checker: %s got %h want %h", $time, what, got, want);
    endtask

    // gray phase to its place in the forward cycle
    function automatic logic [1:0] cycle_pos(input logic [1:0] ph);
        return {ph[1], ph[1] ^ ph[0]};
    endfunction

    function automatic void track_encoder(input logic [1:0] ph);
        logic [1:0] d;
        d = cycle_pos(ph) - cycle_pos(last_phase);
        if (d == 2'd1 && count != POS_MAX) begin
            count = count + 24'sd1;
        end else if (d == 2'd3 && count != POS_MIN) begin
            count = count - 24'sd1;
        end
        last_phase = ph;
    endfunction

    // fold the current position into the running mean at one index
    function automatic void fold_mean(input int idx);
        longint k;
        longint sample;
        longint acc;
        longint quot;
        k      = longint'(runs_done);
        sample = longint'(count) * 256;
        acc    = (k == 0) ? sample : longint'(mean_mem[idx]) * k + sample;
        quot   = acc / (k + 1);
        mean_mem[idx] = quot[MEAN_W-1:0];
    endfunction

    function automatic t_out_item status_after(input t_in_item it);
        t_out_item r;
        int        len;
        int        nxt;
        case (it.action)
            ACT_ENC: begin
                track_encoder({it.enc_a, it.enc_b});
            end
            ACT_TICK: begin
                if (run_on) begin
                    len = (cap_len == '0) ? 1 :
                          (int'(cap_len) > MAX_SAMPLES) ? MAX_SAMPLES : int'(cap_len);
                    fold_mean(tick_idx);
                    nxt = tick_idx + 1;
                    if (nxt >= int'(drv_len)) drive_on = 1'b0;
                    if (nxt >= len) begin
                        count    = '0;
                        tick_idx = 0;
                        run_on   = 1'b0;
                        drive_on = 1'b0;
                        if (runs_done != RUNS_TOP) runs_done = runs_done + 1'b1;
                    end else begin
                        tick_idx = nxt;
                    end
                end
            end
            ACT_START: begin
                if (!run_on) begin
                    if (runs_done >= run_cnt) runs_done = '0;
                    run_on   = 1'b1;
                    tick_idx = 0;
                    drive_on = (drv_len != '0);
                end
            end
            default: ;
        endcase
        r.position      = count;
        r.motor_on      = drive_on;
        r.capturing     = run_on;
        r.runs_finished = runs_done;
        r.series_done   = (runs_done == run_cnt);
        r.mean_value    = (it.action == ACT_READ) ? mean_mem[int'(it.read_index)] : '0;
        return r;
    endfunction

    task automatic compare(input t_out_item got, input t_out_item want);
        if (got.position !== want.position) begin
            report("position", 32'(got.position), 32'(want.position));
        end
        if (got.motor_on !== want.motor_on) begin
            report("motor_on", 32'(got.motor_on), 32'(want.motor_on));
        end
        if (got.capturing !== want.capturing) begin
            report("capturing", 32'(got.capturing), 32'(want.capturing));
        end
        if (got.runs_finished !== want.runs_finished) begin
            report("runs_finished", 32'(got.runs_finished), 32'(want.runs_finished));
        end
        if (got.series_done !== want.series_done) begin
            report("series_done", 32'(got.series_done), 32'(want.series_done));
        end
        if (got.mean_value !== want.mean_value) begin
            report("mean_value", got.mean_value, want.mean_value);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cap_len    = RST_CAPTURE_LENGTH;
            drv_len    = RST_DRIVE_LENGTH;
            run_cnt    = RST_RUN_COUNT;
            last_phase = 2'b00;
            count      = '0;
            tick_idx   = 0;
            run_on     = 1'b0;
            drive_on   = 1'b0;
            runs_done  = '0;
            pending_status.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_status.size() == 0) begin
                    report("result with nothing pending", i_out_item.mean_value, 32'd0);
                end else begin
                    want = pending_status.pop_front();
                    compare(i_out_item, want);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPTURE_LENGTH: cap_len = i_cfg_data;
                    CFG_DRIVE_LENGTH:   drv_len = i_cfg_data;
                    CFG_RUN_COUNT:      run_cnt = i_cfg_data[RUNS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_status.push_back(status_after(i_in_item));
            end
        end
        o_pending    <= pending_status.size();
        o_mismatches <= errors;
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quadrature capture averager. A directed opening
// walks the decoder cases and the odd register settings, then random phases
// run whole capture runs with random encoder motion, ticks and mean reads,
// under random source gaps and sink stalls. Checking lives in qca_checker.
// ----------------------------------------------------------------------------
module tb;
    import qca_pkg::*;

    // register index that maps to nothing; a write to it must be dropped
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 1800;
    localparam int DRAIN_CYCLES   = 100;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [LEN_W-1:0]   cfg_data  = '0;
    int                 mismatches;
    int                 pending;

    // no source gaps and no sink stalls while set
    bit                 calm = 1'b0;
    int                 idle_cycles = 0;

    // Stimulus-side view of the block. It is only used to keep the stimulus
    // legal: a mean is never read, nor folded with a nonzero run weight,
    // before a first run of some series has written it. Every write of the
    // store starts at index 0 and moves up, so what has been written is
    // always the prefix [0, filled).
    logic [LEN_W-1:0]   trk_cap = RST_CAPTURE_LENGTH;
    logic [RUNS_W-1:0]  trk_rc  = RST_RUN_COUNT;
    bit                 trk_run = 1'b0;
    int                 trk_tick = 0;
    int                 trk_runs = 0;
    int                 filled = 0;
    logic [1:0]         trk_phase = 2'b00;
    int                 sent = 0;

    quadrature_capture_averager_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    qca_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap and stall lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int pick_hold();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Sink side: raise stall at random for a while, never while calm.
    initial begin
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < 20) begin
                out_stall <= 1'b1;
                repeat (pick_hold()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too
    // long. The slowest item (a tick inside a run) plus the longest gap and
    // the longest stall stays far below the limit.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quadrature_capture_averager_top: mismatch");
            $finish;
        end
    end

    // Ticks per run as the block counts them.
    function automatic int len_of(input logic [LEN_W-1:0] cap);
        if (cap == '0) return 1;
        if (int'(cap) > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(cap);
    endfunction

    // Present one item and hold it until the transfer. Valid stays high on
    // return so that a back-to-back item needs no second assignment in the
    // same time step; a gap lowers it first.
    task automatic push(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Advance the stimulus-side view, then send.
    task automatic send(input t_in_item it);
        case (it.action)
            ACT_ENC: begin
                trk_phase = {it.enc_a, it.enc_b};
            end
            ACT_TICK: begin
                if (trk_run) begin
                    // a fold with zero weight is what writes an entry
                    if (trk_runs == 0 && trk_tick + 1 > filled) filled = trk_tick + 1;
                    if (trk_tick + 1 >= len_of(trk_cap)) begin
                        trk_run  = 1'b0;
                        trk_tick = 0;
                        if (trk_runs < 255) trk_runs++;
                    end else begin
                        trk_tick++;
                    end
                end
            end
            ACT_START: begin
                if (!trk_run) begin
                    if (trk_runs >= int'(trk_rc)) trk_runs = 0;
                    trk_run  = 1'b1;
                    trk_tick = 0;
                end
            end
            default: ;
        endcase
        sent++;
        push(it);
    endtask

    // Unused fields carry random bits so that every input bit toggles.
    task automatic send_enc(input logic [1:0] ph);
        t_in_item it;
        it.action     = ACT_ENC;
        it.enc_a      = ph[1];
        it.enc_b      = ph[0];
        it.read_index = TICK_W'($urandom);
        send(it);
    endtask

    task automatic send_act(input t_action act);
        t_in_item it;
        it.action     = act;
        it.enc_a      = 1'($urandom);
        it.enc_b      = 1'($urandom);
        it.read_index = TICK_W'($urandom);
        send(it);
    endtask

    task automatic send_read(input int idx);
        t_in_item it;
        it.action     = ACT_READ;
        it.enc_a      = 1'($urandom);
        it.enc_b      = 1'($urandom);
        it.read_index = TICK_W'(idx);
        send(it);
    endtask

    // Move the encoder: mostly legal steps either way, some holds and some
    // two-bit jumps that the decoder must not count.
    task automatic gray_move();
        int         r;
        logic [1:0] pos;
        r   = $urandom_range(0, 99);
        pos = {trk_phase[1], trk_phase[1] ^ trk_phase[0]};
        if (r < 60) begin
            pos = pos + 2'd1;
        end else if (r < 85) begin
            pos = pos - 2'd1;
        end else if (r < 93) begin
            pos = pos + 2'd2;
        end
        send_enc({pos[1], pos[1] ^ pos[0]});
    endtask

    // Any action with random content; reads stay inside the written prefix.
    task automatic noise();
        t_in_item it;
        it.action     = t_action'(2'($urandom_range(0, 3)));
        it.enc_a      = 1'($urandom);
        it.enc_b      = 1'($urandom);
        it.read_index = TICK_W'($urandom);
        if (it.action == ACT_READ) begin
            if (filled == 0) begin
                it.action = ACT_ENC;
            end else begin
                it.read_index = TICK_W'($urandom_range(0, filled - 1));
            end
        end
        send(it);
    endtask

    // One whole capture run with encoder motion, reads and stray starts mixed
    // in between the ticks.
    task automatic run_through();
        int r;
        send_act(ACT_START);
        while (trk_run) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_act(ACT_TICK);
            end else if (r < 85) begin
                gray_move();
            end else if (r < 95 && filled > 0) begin
                send_read($urandom_range(0, filled - 1));
            end else if (r < 97) begin
                send_act(ACT_START);
            end else begin
                noise();
            end
        end
    endtask

    // Tick the current run to its end, with a little motion along the way.
    task automatic finish_run();
        while (trk_run) begin
            if ($urandom_range(0, 4) == 0) begin
                gray_move();
            end else begin
                send_act(ACT_TICK);
            end
        end
    endtask

    // Drop valid and wait until every result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_CAPTURE_LENGTH: trk_cap = val;
            CFG_RUN_COUNT:      trk_rc  = val[RUNS_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers. When the next start will not restart the
    // series, later runs fold into existing means, so hold the run length
    // inside the written prefix.
    task automatic configure(input logic [LEN_W-1:0] cap, input logic [LEN_W-1:0] drv,
                             input logic [RUNS_W-1:0] rc);
        logic [LEN_W-1:0] c;
        c = cap;
        if (trk_runs > 0 && trk_runs < int'(rc) && len_of(c) > filled) c = LEN_W'(filled);
        write_reg(CFG_CAPTURE_LENGTH, c);
        write_reg(CFG_DRIVE_LENGTH, drv);
        write_reg(CFG_RUN_COUNT, {4'($urandom), rc});
    endtask

    initial begin
        int               ph;
        int               target;
        int               r;
        logic [LEN_W-1:0] cap;
        logic [LEN_W-1:0] drv;
        logic [RUNS_W-1:0] rc;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decoder cases from the reset phase 00: a hold, a full forward turn,
        // one step back, then two-bit jumps that must leave the count alone.
        send_enc(2'b00);
        send_enc(2'b01);
        send_enc(2'b11);
        send_enc(2'b10);
        send_enc(2'b00);
        send_enc(2'b10);
        send_enc(2'b01);
        send_enc(2'b10);
        // tick with no run is ignored; a second start inside a run too
        send_act(ACT_TICK);
        send_act(ACT_START);
        send_act(ACT_START);
        send_act(ACT_TICK);
        send_enc(2'b00);
        // shorten the run under way to a few ticks, tick it out with drive
        // still on, then read both ends
        settle();
        write_reg(CFG_CAPTURE_LENGTH, 12'd6);
        finish_run();
        send_read(0);
        send_read(filled - 1);
        settle();

        // Zero capture length acts as one, zero drive length never drives;
        // a run count of one makes every start after a run restart the series.
        configure('0, '0, 8'd1);
        send_act(ACT_START);
        send_act(ACT_TICK);
        send_act(ACT_START);
        send_act(ACT_TICK);
        send_read(0);
        settle();

        // Drive length beyond the run: the end of the run turns drive off.
        configure(12'd3, '1, 8'd255);
        send_act(ACT_START);
        send_act(ACT_TICK);
        send_act(ACT_TICK);
        send_act(ACT_TICK);
        settle();

        // Lower the run count below the runs done: series_done must read 0.
        // The spare index must change nothing.
        write_reg(CFG_RUN_COUNT, 12'd1);
        write_reg(CFG_SPARE, LEN_W'($urandom));
        send_act(ACT_TICK);
        send_read(2);
        settle();

        // Top run count with one-tick runs: walk runs_finished through its
        // whole range, finish the series, and restart it.
        configure(12'd1, 12'd1, 8'd255);
        repeat (260) begin
            send_act(ACT_START);
            if ($urandom_range(0, 3) == 0) gray_move();
            send_act(ACT_TICK);
        end
        settle();

        // Random phases until the item total is reached: short runs in short
        // series, random settings, one phase in four without any idling.
        ph = 0;
        while (sent < TOTAL_ITEMS) begin
            calm = (ph % 4 == 3);
            r    = $urandom_range(0, 9);
            cap  = (r < 7) ? LEN_W'($urandom_range(1, 16)) :
                   (r < 9) ? LEN_W'($urandom_range(17, 64)) : '0;
            r    = $urandom_range(0, 9);
            drv  = (r < 5) ? LEN_W'($urandom_range(0, int'(cap) + 2)) :
                   (r < 7) ? '0 : LEN_W'($urandom);
            r    = $urandom_range(0, 9);
            rc   = (ph == 0) ? '0 :
                   (r < 8) ? RUNS_W'($urandom_range(1, 6)) : RUNS_W'($urandom_range(7, 255));
            configure(cap, drv, rc);
            target = sent + $urandom_range(150, 250);
            while (sent < target) begin
                if ($urandom_range(0, 99) < 75) begin
                    run_through();
                end else begin
                    repeat ($urandom_range(1, 6)) noise();
                end
            end
            finish_run();
            settle();
            ph++;
        end
        calm = 1'b0;

        // let anything late show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("quadrature_capture_averager_top: match");
        end else begin
            $display("quadrature_capture_averager_top: mismatch");
        end
        $finish;
    end

endmodule

@@ quadrature_capture_averager_top.f @@
sv/qca_pkg.sv
sv/qca_run_ctrl.sv
sv/qca_mean_unit.sv
sv/quadrature_capture_averager_top.sv
dv/qca_checker.sv
dv/tb.sv
